// ===== src/pal_pkg.sv =====
// Shared types and constants for the positional array list core.
// Holds the command codes, status codes and the cell control struct.
// No dependencies.
`default_nettype none

package pal_pkg;

	// Default list capacity in entries.
	localparam int CAPACITY_DEF = 16;

	// Field widths fixed by the command and result formats.
	localparam int CMD_W    = 2;
	localparam int POS_W    = 8;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_READ   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_WRITE  = 2'd3
	} cmd_t;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

	// Control broadcast to every cell of the row.
	typedef struct packed {
		logic             ins;   // shift up from the target cell, load value there
		logic             del;   // shift down from the target cell
		logic             wr;    // overwrite the target cell
		logic [POS_W-1:0] idx;   // 0-based target index
	} ctrl_t;

endpackage

`default_nettype wire

// ===== src/pal_ctrl.sv =====
// Command decoder for the positional array list core.
// Checks a command against the current length and drives the cell control.
// Depends on pal_pkg.
`default_nettype none

module pal_ctrl #(
	parameter int CAPACITY = pal_pkg::CAPACITY_DEF,
	parameter int LEN_W    = $clog2(CAPACITY + 1)
) (
	input  wire logic                           accept,
	input  wire logic [pal_pkg::CMD_W-1:0]      cmd,
	input  wire logic [pal_pkg::POS_W-1:0]      position,
	input  wire logic [LEN_W-1:0]               len,
	output pal_pkg::ctrl_t                      ctrl,
	output logic      [pal_pkg::STATUS_W-1:0]   status,
	output logic                                rd_data,
	output logic      [LEN_W-1:0]               len_next
);

	localparam logic [pal_pkg::POS_W:0] CAP_X = (pal_pkg::POS_W + 1)'(CAPACITY);

	logic [pal_pkg::POS_W:0] len_x;
	logic [pal_pkg::POS_W:0] pos_x;
	logic                    pos_zero;
	logic                    ok;
	pal_pkg::cmd_t           op;

	assign len_x    = (pal_pkg::POS_W + 1)'(len);
	assign pos_x    = {1'b0, position};
	assign pos_zero = (position == '0);
	assign op       = pal_pkg::cmd_t'(cmd);

	// Status check; full takes precedence over position for inserts.
	always_comb begin
		unique case (op)
			pal_pkg::CMD_READ, pal_pkg::CMD_DELETE: begin
				if (len == '0)
					status = pal_pkg::ST_EMPTY;
				else if (pos_zero || pos_x > len_x)
					status = pal_pkg::ST_BADPOS;
				else
					status = pal_pkg::ST_OK;
			end
			pal_pkg::CMD_INSERT: begin
				if (len_x >= CAP_X)
					status = pal_pkg::ST_FULL;
				else if (pos_zero || pos_x > len_x + 1'b1)
					status = pal_pkg::ST_BADPOS;
				else
					status = pal_pkg::ST_OK;
			end
			pal_pkg::CMD_WRITE: begin
				if (pos_zero || pos_x > len_x)
					status = pal_pkg::ST_BADPOS;
				else
					status = pal_pkg::ST_OK;
			end
			default: status = pal_pkg::ST_BADPOS;
		endcase
	end

	assign ok = accept && (status == pal_pkg::ST_OK);

	// Cell control is only asserted for a successful command.
	assign ctrl.ins = ok && (op == pal_pkg::CMD_INSERT);
	assign ctrl.del = ok && (op == pal_pkg::CMD_DELETE);
	assign ctrl.wr  = ok && (op == pal_pkg::CMD_WRITE);
	assign ctrl.idx = position - 1'b1;

	// Data is returned for successful reads and deletes.
	assign rd_data = (status == pal_pkg::ST_OK) &&
		(op == pal_pkg::CMD_READ || op == pal_pkg::CMD_DELETE);

	// Length after this command.
	always_comb begin
		if (ctrl.ins)
			len_next = len + 1'b1;
		else if (ctrl.del)
			len_next = len - 1'b1;
		else
			len_next = len;
	end

endmodule

`default_nettype wire

// ===== src/pal_cell.sv =====
// One storage cell of the positional array list core.
// Holds one entry, shifts with its neighbors and feeds the read chain.
// Depends on pal_pkg.
`default_nettype none

module pal_cell #(
	parameter int IDX = 0
) (
	input  wire logic                          clk,
	input  wire pal_pkg::ctrl_t                ctrl,
	input  wire logic [pal_pkg::DATA_W-1:0]    value,
	input  wire logic [pal_pkg::DATA_W-1:0]    from_left,
	input  wire logic [pal_pkg::DATA_W-1:0]    from_right,
	input  wire logic [pal_pkg::DATA_W-1:0]    chain_in,
	output logic      [pal_pkg::DATA_W-1:0]    entry,
	output logic      [pal_pkg::DATA_W-1:0]    chain_out
);

	localparam logic [pal_pkg::POS_W-1:0] MY_IDX = pal_pkg::POS_W'(IDX);

	logic [pal_pkg::DATA_W-1:0] entry_q;
	logic                       hit;
	logic                       above;

	assign hit   = (ctrl.idx == MY_IDX);
	assign above = (MY_IDX > ctrl.idx);

	// Entry update: load, shift up from the left, or shift down from the right.
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (hit)
				entry_q <= value;
			else if (above)
				entry_q <= from_left;
		end else if (ctrl.del) begin
			if (hit || above)
				entry_q <= from_right;
		end else if (ctrl.wr && hit) begin
			entry_q <= value;
		end
	end

	assign entry = entry_q;

	// Read chain: the addressed cell ORs its entry into the passing word.
	assign chain_out = chain_in | (hit ? entry_q : '0);

endmodule

`default_nettype wire

// ===== src/positional_array_list_core.sv =====
// Positional array list core: a bounded ordered list held in a row of cells.
// Latency: a command accepted at one edge has its result strobed on done in
// the following cycle. Throughput: one command per cycle, busy stays low.
// Every cell compares its index with the position, so all entries shift at once.
// Reset clears the length and the result strobe; entry contents are not reset.
// The receiver cannot stall: done is high for one cycle per accepted command.
`default_nettype none

module positional_array_list_core #(
	parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic        [pal_pkg::CMD_W-1:0]     cmd,
	input  wire logic        [pal_pkg::POS_W-1:0]     position,
	input  wire logic signed [pal_pkg::DATA_W-1:0]    value,
	output logic                                      done,
	output logic             [pal_pkg::STATUS_W-1:0]  status,
	output logic signed      [pal_pkg::DATA_W-1:0]    data,
	output logic             [pal_pkg::COUNT_W-1:0]   count
);

	localparam int LEN_W = $clog2(CAPACITY + 1);

	logic                             accept;
	pal_pkg::ctrl_t                   ctrl;
	logic [pal_pkg::STATUS_W-1:0]     status_c;
	logic                             rd_data;
	logic [LEN_W-1:0]                 len_q;
	logic [LEN_W-1:0]                 len_next;
	logic [LEN_W+pal_pkg::COUNT_W-1:0] len_ext;
	logic [pal_pkg::DATA_W-1:0]       ent   [CAPACITY];
	logic [pal_pkg::DATA_W-1:0]       chain [CAPACITY+1];
	logic                             done_q;
	logic [pal_pkg::STATUS_W-1:0]     status_q;
	logic [pal_pkg::DATA_W-1:0]       data_q;
	logic [pal_pkg::COUNT_W-1:0]      count_q;

	// The core never stalls: busy is tied low.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	pal_ctrl #(
		.CAPACITY (CAPACITY),
		.LEN_W    (LEN_W)
	) u_ctrl (
		.accept   (accept),
		.cmd      (cmd),
		.position (position),
		.len      (len_q),
		.ctrl     (ctrl),
		.status   (status_c),
		.rd_data  (rd_data),
		.len_next (len_next)
	);

	// Row of cells; the end cells take their own entry where no neighbor exists.
	assign chain[0] = '0;

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [pal_pkg::DATA_W-1:0] left_w;
		logic [pal_pkg::DATA_W-1:0] right_w;

		if (k == 0) begin : g_first
			assign left_w = ent[k];
		end else begin : g_mid_l
			assign left_w = ent[k-1];
		end

		if (k == CAPACITY - 1) begin : g_last
			assign right_w = ent[k];
		end else begin : g_mid_r
			assign right_w = ent[k+1];
		end

		pal_cell #(
			.IDX (k)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.value      (value),
			.from_left  (left_w),
			.from_right (right_w),
			.chain_in   (chain[k]),
			.entry      (ent[k]),
			.chain_out  (chain[k+1])
		);
	end

	// Length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			len_q <= '0;
		else if (accept)
			len_q <= len_next;
	end

	assign len_ext = {{pal_pkg::COUNT_W{1'b0}}, len_next};

	// Result register; one beat per accepted command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_c;
			data_q   <= rd_data ? chain[CAPACITY] : '0;
			count_q  <= len_ext[pal_pkg::COUNT_W-1:0];
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign data   = data_q;
	assign count  = count_q;

	// Every accepted command yields a result beat in the next cycle.
	a_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("missing result beat");

	// The length never exceeds the capacity.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(LEN_W + 1)'(len_q) <= (LEN_W + 1)'(CAPACITY))
		else $error("length above capacity");

	// A full report means the list is still at capacity.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == pal_pkg::ST_FULL) |->
		((LEN_W + 1)'(len_q) == (LEN_W + 1)'(CAPACITY)))
		else $error("full status with list not full");

	// A failed command leaves the length unchanged.
	a_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status_c != pal_pkg::ST_OK) |=> (len_q == $past(len_q)))
		else $error("length changed on failed command");

endmodule

`default_nettype wire

// ===== bench/positional_array_list_core_tb.sv =====
// Self-checking testbench for the positional array list core.
// Drives read, insert, delete and write commands and checks every result beat.
// Depends on pal_pkg and positional_array_list_core.
`default_nettype none

module positional_array_list_core_tb;

	localparam int CAP        = pal_pkg::CAPACITY_DEF;
	localparam int RAND_ITEMS = 1030;
	localparam int PHASE_LEN  = 120;
	localparam int QUIET_MAX  = 2000;
	localparam int REPORT_MAX = 10;

	typedef struct {
		pal_pkg::cmd_t                     op;
		logic [pal_pkg::POS_W-1:0]         pos;
		logic signed [pal_pkg::DATA_W-1:0] val;
	} list_cmd_t;

	typedef struct {
		logic [pal_pkg::STATUS_W-1:0]      st;
		logic signed [pal_pkg::DATA_W-1:0] dat;
		logic [pal_pkg::COUNT_W-1:0]       len;
	} list_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                              start    = 1'b0;
	logic [pal_pkg::CMD_W-1:0]         cmd      = '0;
	logic [pal_pkg::POS_W-1:0]         position = '0;
	logic signed [pal_pkg::DATA_W-1:0] value    = '0;

	logic                              busy;
	logic                              done;
	logic [pal_pkg::STATUS_W-1:0]      status;
	logic signed [pal_pkg::DATA_W-1:0] data;
	logic [pal_pkg::COUNT_W-1:0]       count;

	// Commands waiting to be sent and results waiting to arrive.
	list_cmd_t    pending_cmds[$];
	list_result_t expected_results[$];

	// Predicted list contents.
	logic signed [pal_pkg::DATA_W-1:0] list_store [CAP];
	int                                list_len = 0;

	// Length as the command generator sees it, used to aim positions.
	int gen_len = 0;

	int sent_items    = 0;
	int fail_count    = 0;
	int mismatch_seen = 0;
	int quiet_cycles  = 0;

	positional_array_list_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.position (position),
		.value    (value),
		.done     (done),
		.status   (status),
		.data     (data),
		.count    (count)
	);

	always #4 clk = ~clk;

	// Apply one command to the predicted list and return the expected result.
	task automatic apply_command(input pal_pkg::cmd_t op,
			input logic [pal_pkg::POS_W-1:0] pos,
			input logic signed [pal_pkg::DATA_W-1:0] val, output list_result_t res);
		int p;
		int k;
		p       = pos;
		res.st  = pal_pkg::ST_OK;
		res.dat = '0;
		case (op)
			pal_pkg::CMD_READ: begin
				if (list_len == 0)
					res.st = pal_pkg::ST_EMPTY;
				else if (p < 1 || p > list_len)
					res.st = pal_pkg::ST_BADPOS;
				else
					res.dat = list_store[p-1];
			end
			pal_pkg::CMD_INSERT: begin
				if (list_len >= CAP)
					res.st = pal_pkg::ST_FULL;
				else if (p < 1 || p > list_len + 1)
					res.st = pal_pkg::ST_BADPOS;
				else begin
					for (k = list_len; k > p - 1; k--)
						list_store[k] = list_store[k-1];
					list_store[p-1] = val;
					list_len++;
				end
			end
			pal_pkg::CMD_DELETE: begin
				if (list_len == 0)
					res.st = pal_pkg::ST_EMPTY;
				else if (p < 1 || p > list_len)
					res.st = pal_pkg::ST_BADPOS;
				else begin
					res.dat = list_store[p-1];
					for (k = p - 1; k + 1 < list_len; k++)
						list_store[k] = list_store[k+1];
					list_len--;
				end
			end
			default: begin
				if (p < 1 || p > list_len)
					res.st = pal_pkg::ST_BADPOS;
				else
					list_store[p-1] = val;
			end
		endcase
		res.len = pal_pkg::COUNT_W'(list_len);
	endtask

	// Queue a command and follow the length it leaves behind.
	task automatic add_cmd(input pal_pkg::cmd_t op, input int pos,
			input logic signed [pal_pkg::DATA_W-1:0] val);
		list_cmd_t c;
		c.op  = op;
		c.pos = pal_pkg::POS_W'(pos);
		c.val = val;
		pending_cmds.push_back(c);
		if (op == pal_pkg::CMD_INSERT && gen_len < CAP && pos >= 1 && pos <= gen_len + 1)
			gen_len++;
		else if (op == pal_pkg::CMD_DELETE && pos >= 1 && pos <= gen_len)
			gen_len--;
	endtask

	// Random value, with the extremes of the signed range mixed in.
	function automatic logic signed [pal_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Position aimed mostly inside the list, sometimes just outside, rarely anywhere.
	function automatic int pick_position(input pal_pkg::cmd_t op);
		int top;
		int r;
		top = (op == pal_pkg::CMD_INSERT) ? gen_len + 1 : gen_len;
		r   = $urandom_range(0, 99);
		if (r < 10)
			return (top >= 1) ? top : 1;
		else if (r < 78)
			return (top >= 1) ? $urandom_range(1, top) : $urandom_range(0, 2);
		else if (r < 84)
			return 0;
		else if (r < 90)
			return top + 1;
		else
			return $urandom_range(0, 255);
	endfunction

	// Command mix for a phase: 0 grows the list, 1 shrinks it, 2 is balanced.
	function automatic pal_pkg::cmd_t pick_op(input int mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			0: begin
				if (r < 60) return pal_pkg::CMD_INSERT;
				if (r < 75) return pal_pkg::CMD_READ;
				if (r < 85) return pal_pkg::CMD_WRITE;
				return pal_pkg::CMD_DELETE;
			end
			1: begin
				if (r < 60) return pal_pkg::CMD_DELETE;
				if (r < 75) return pal_pkg::CMD_INSERT;
				if (r < 90) return pal_pkg::CMD_READ;
				return pal_pkg::CMD_WRITE;
			end
			default: return pal_pkg::cmd_t'(r % 4);
		endcase
	endfunction

	// Driver: present the head of the pending queue, idling at random except while items 300 to 499 are sent.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				void'(pending_cmds.pop_front());
				sent_items++;
			end
			if (pending_cmds.size() > 0 &&
					((sent_items >= 300 && sent_items < 500) || $urandom_range(0, 99) >= 32)) begin
				start    <= 1'b1;
				cmd      <= pending_cmds[0].op;
				position <= pending_cmds[0].pos;
				value    <= pending_cmds[0].val;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: predict each accepted command, then check each result beat.
	always @(posedge clk) begin
		list_result_t exp_res;
		if (arst_n) begin
			if (start && !busy) begin
				apply_command(pal_pkg::cmd_t'(cmd), position, value, exp_res);
				expected_results.push_back(exp_res);
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (mismatch_seen < REPORT_MAX)
						$display("Unexpected result beat: status %0d data %0d count %0d",
							status, data, count);
					mismatch_seen++;
				end else begin
					exp_res = expected_results.pop_front();
					if (status !== exp_res.st || data !== exp_res.dat ||
							count !== exp_res.len) begin
						fail_count++;
						if (mismatch_seen < REPORT_MAX)
							$display({"Result mismatch: status %0d/%0d data %0d/%0d",
								" count %0d/%0d (exp/got)"},
								exp_res.st, status, exp_res.dat, data, exp_res.len, count);
						mismatch_seen++;
					end
				end
			end
		end
	end

	// Watchdog on cycles in which no beat moves on either side.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_MAX) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int i;
		int mode;
		pal_pkg::cmd_t op;

		// Directed: empty list cases, bad positions, front, middle and append inserts.
		add_cmd(pal_pkg::CMD_READ,   1,   32'sd5);
		add_cmd(pal_pkg::CMD_DELETE, 1,   32'sd5);
		add_cmd(pal_pkg::CMD_WRITE,  1,   32'sd5);
		add_cmd(pal_pkg::CMD_INSERT, 0,   32'sd7);
		add_cmd(pal_pkg::CMD_INSERT, 2,   32'sd7);
		add_cmd(pal_pkg::CMD_INSERT, 1,   32'sh8000_0000);
		add_cmd(pal_pkg::CMD_INSERT, 2,   32'sh7FFF_FFFF);
		add_cmd(pal_pkg::CMD_INSERT, 1,   -32'sd1);
		add_cmd(pal_pkg::CMD_INSERT, 2,   32'sh5A5A_A5A5);
		add_cmd(pal_pkg::CMD_READ,   1,   32'sd0);
		add_cmd(pal_pkg::CMD_READ,   4,   32'sd0);
		add_cmd(pal_pkg::CMD_READ,   5,   32'sd0);
		add_cmd(pal_pkg::CMD_READ,   0,   32'sd0);
		add_cmd(pal_pkg::CMD_READ,   255, 32'sd0);
		add_cmd(pal_pkg::CMD_WRITE,  3,   32'sd0);
		add_cmd(pal_pkg::CMD_WRITE,  0,   32'sd9);
		add_cmd(pal_pkg::CMD_WRITE,  200, 32'sd9);
		add_cmd(pal_pkg::CMD_DELETE, 2,   32'sd0);
		add_cmd(pal_pkg::CMD_DELETE, 4,   32'sd0);
		add_cmd(pal_pkg::CMD_DELETE, 0,   32'sd0);
		add_cmd(pal_pkg::CMD_INSERT, 5,   32'sd3);
		add_cmd(pal_pkg::CMD_READ,   3,   32'sd0);
		add_cmd(pal_pkg::CMD_DELETE, 3,   32'sd0);

		// Random phases that fill the list to capacity, drain it, and mix.
		for (i = 0; i < RAND_ITEMS; i++) begin
			mode = (i / PHASE_LEN) % 3;
			op   = pick_op(mode);
			add_cmd(op, pick_position(op), pick_value());
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the last command and its result, then watch for stray beats.
		while (pending_cmds.size() != 0 || start)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0)
			fail_count++;

		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== positional_array_list_core.f =====
src/pal_pkg.sv
src/pal_ctrl.sv
src/pal_cell.sv
src/positional_array_list_core.sv
bench/positional_array_list_core_tb.sv
